// ----- rtl/core/gstr_pkg.sv -----
// Shared constants, types and helpers for the group-sum triple rank sorter.
`timescale 1ns / 1ps

package gstr_pkg;

    // Capacity and group size
    localparam int MAX_GROUPS        = 16;
    localparam int MEMBERS_PER_GROUP = 11;

    // Field and counter widths
    localparam int SCORE_W  = 16;
    localparam int TOTAL_W  = 20;
    localparam int GIDX_W   = 4;
    localparam int KEY_W    = 2;
    localparam int IDX_W    = $clog2(MAX_GROUPS);
    localparam int CNT_W    = $clog2(MAX_GROUPS + 1);
    localparam int MCNT_W   = 4;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 8;
    localparam int M_USER_W = 3;

    // Ranking keys
    typedef logic [KEY_W-1:0] rank_key_t;
    localparam rank_key_t KEY_A = 2'd0;
    localparam rank_key_t KEY_B = 2'd1;
    localparam rank_key_t KEY_C = 2'd2;

    // Three group totals
    typedef struct packed {
        logic [TOTAL_W-1:0] c;
        logic [TOTAL_W-1:0] b;
        logic [TOTAL_W-1:0] a;
    } totals_t;

    // One closed group as it travels from front to back
    typedef struct packed {
        logic    finish;
        totals_t tot;
    } group_rec_t;

    // Select the total that ranks the current list
    function automatic logic [TOTAL_W-1:0] key_total(totals_t t, rank_key_t k);
        logic [TOTAL_W-1:0] v;
        case (k)
            KEY_A:   v = t.a;
            KEY_B:   v = t.b;
            default: v = t.c;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/group_sum_triple_rank_sorter.sv -----
// Top level of the group-sum triple rank sorter.
`timescale 1ns / 1ps

// Usage
// Slave channel: one member request per handshake; s_tdata carries three
// 16-bit scores, s_tlast marks the final group (looked at only on a group's
// 11th member). Every 11 members close one group; up to 16 groups are kept
// per set, later groups are summed and dropped.
// Master channel: after the final group, three lists of group arrival indices,
// ranked descending by total A, then B, then C, each stable against the list
// before it. m_tlast closes each list, m_tuser[2] closes the third.
// Throughput: members are taken at one per cycle while the record queue has
// room. After the final member its record passes through the queue to the
// back end; each list is then sorted by odd-even exchange rounds in the rank
// row and emitted one group at a time. The front keeps accepting while the
// back sorts until its two-entry record queue is full.
// Reset clears counts, totals and the output register; no clearing pass.
// A stalled m_tready holds the output register, then the back end, then the
// queue, and finally s_tready drops.
module group_sum_triple_rank_sorter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gstr_pkg::S_DATA_W-1:0] s_tdata,   // score_a, score_b, score_c
    input  logic                          s_tlast,   // end_of_set
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gstr_pkg::M_DATA_W-1:0] m_tdata,   // group_index, zero pad
    output logic [gstr_pkg::M_USER_W-1:0] m_tuser,   // ranking_key, end_of_run
    output logic                          m_tlast    // end_of_list
);

    logic                 q_push;
    logic                 q_full;
    logic                 q_valid;
    logic                 q_pop;
    gstr_pkg::group_rec_t push_rec;
    gstr_pkg::group_rec_t pop_rec;

    gstr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_rec    (push_rec)
    );

    gstr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_rec (push_rec),
        .full     (q_full),
        .valid    (q_valid),
        .pop      (q_pop),
        .pop_rec  (pop_rec)
    );

    gstr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_rec    (pop_rec),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // End of run only closes a list
    a_run_closes_list: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> m_tlast)
        else $error("end_of_run without end_of_list");

    // End of run only on the third ranking
    a_run_on_key_c: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> (m_tuser[1:0] == gstr_pkg::KEY_C))
        else $error("end_of_run on a ranking other than C");

    // Front never pushes into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("group record pushed into full queue");

    // A queue that fills stops the slave side
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !s_tready && !q_push)
        else $error("slave request taken while queue full");

endmodule

// ----- rtl/core/gstr_front.sv -----
// Front end: accepts member requests and sums them into closed group records.
`timescale 1ns / 1ps

module gstr_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gstr_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    input  logic                          q_full,
    output logic                          q_push,
    output gstr_pkg::group_rec_t          q_rec
);

    logic [gstr_pkg::MCNT_W-1:0]  member_count_reg, member_count_next;
    gstr_pkg::totals_t            run_reg, run_next;
    gstr_pkg::totals_t            sum;
    logic                         accept;
    logic                         close;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign close    = (member_count_reg ==
                       gstr_pkg::MCNT_W'(gstr_pkg::MEMBERS_PER_GROUP - 1));

    // Add this member's scores to the running totals
    assign sum.a = run_reg.a + gstr_pkg::TOTAL_W'(s_tdata[15:0]);
    assign sum.b = run_reg.b + gstr_pkg::TOTAL_W'(s_tdata[31:16]);
    assign sum.c = run_reg.c + gstr_pkg::TOTAL_W'(s_tdata[47:32]);

    // Push a record on the last member of a group
    assign q_push     = accept && close;
    assign q_rec.tot  = sum;
    assign q_rec.finish = s_tlast;

    // Advance member count, clear totals when the group closes
    always_comb
    begin
        member_count_next = member_count_reg;
        run_next          = run_reg;
        if (accept)
        begin
            if (close)
            begin
                member_count_next = '0;
                run_next          = '0;
            end
            else
            begin
                member_count_next = member_count_reg + 1'b1;
                run_next          = sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            member_count_reg <= '0;
            run_reg          <= '0;
        end
        else
        begin
            member_count_reg <= member_count_next;
            run_reg          <= run_next;
        end
    end

endmodule

// ----- rtl/core/gstr_queue.sv -----
// Two-entry queue of group records between front and back.
`timescale 1ns / 1ps

module gstr_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  gstr_pkg::group_rec_t push_rec,
    output logic                 full,
    output logic                 valid,
    input  logic                 pop,
    output gstr_pkg::group_rec_t pop_rec
);

    gstr_pkg::group_rec_t entry_reg [2];
    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    logic [1:0]           count_reg, count_next;
    logic                 do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign valid   = (count_reg != 2'd0);
    assign pop_rec = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold record payload
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

// ----- rtl/core/gstr_back.sv -----
// Back end: stores group totals, ranks them three times and emits the lists.
`timescale 1ns / 1ps

module gstr_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  gstr_pkg::group_rec_t          q_rec,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gstr_pkg::M_DATA_W-1:0] m_tdata,
    output logic [gstr_pkg::M_USER_W-1:0] m_tuser,
    output logic                          m_tlast
);

    typedef enum logic [1:0] {ST_LOAD, ST_SORT, ST_EMIT} state_t;

    state_t                          state_reg, state_next;
    logic [gstr_pkg::CNT_W-1:0]      count_reg, count_next;
    gstr_pkg::rank_key_t             key_reg, key_next;
    logic [gstr_pkg::IDX_W-1:0]      round_reg, round_next;
    logic [gstr_pkg::IDX_W-1:0]      emit_k_reg, emit_k_next;
    logic                            out_valid_reg, out_valid_next;
    logic [gstr_pkg::GIDX_W-1:0]     out_idx_reg, out_idx_next;
    gstr_pkg::rank_key_t             out_key_reg, out_key_next;
    logic                            out_last_reg, out_last_next;
    logic                            out_run_reg, out_run_next;

    // Rank row: position p holds a group's arrival index and totals
    logic [gstr_pkg::IDX_W-1:0]      pos_idx_reg [gstr_pkg::MAX_GROUPS];
    logic [gstr_pkg::IDX_W-1:0]      pos_idx_next [gstr_pkg::MAX_GROUPS];
    gstr_pkg::totals_t               pos_tot_reg [gstr_pkg::MAX_GROUPS];
    gstr_pkg::totals_t               pos_tot_next [gstr_pkg::MAX_GROUPS];

    logic                            load_out;
    logic                            emit_last;

    assign q_pop     = (state_reg == ST_LOAD) && q_valid;
    assign load_out  = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);
    assign emit_last = ((gstr_pkg::CNT_W'(emit_k_reg) + 1'b1) == count_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = gstr_pkg::M_DATA_W'(out_idx_reg);
    assign m_tuser  = {out_run_reg, out_key_reg};
    assign m_tlast  = out_last_reg;

    // Rank row update: load new groups, or one odd-even exchange round
    always_comb
    begin
        for (int p = 0; p < gstr_pkg::MAX_GROUPS; p++)
        begin
            pos_idx_next[p] = pos_idx_reg[p];
            pos_tot_next[p] = pos_tot_reg[p];
        end
        if (q_pop && (count_reg < gstr_pkg::CNT_W'(gstr_pkg::MAX_GROUPS)))
        begin
            pos_idx_next[count_reg[gstr_pkg::IDX_W-1:0]] = count_reg[gstr_pkg::IDX_W-1:0];
            pos_tot_next[count_reg[gstr_pkg::IDX_W-1:0]] = q_rec.tot;
        end
        else if (state_reg == ST_SORT)
        begin
            for (int p = 0; p < gstr_pkg::MAX_GROUPS - 1; p++)
            begin
                // Swap only on a strictly smaller upper entry to keep ties stable
                if ((1'(p % 2) == round_reg[0]) &&
                    (gstr_pkg::CNT_W'(p + 1) < count_reg) &&
                    (gstr_pkg::key_total(pos_tot_reg[p], key_reg) <
                     gstr_pkg::key_total(pos_tot_reg[p+1], key_reg)))
                begin
                    pos_idx_next[p]   = pos_idx_reg[p+1];
                    pos_tot_next[p]   = pos_tot_reg[p+1];
                    pos_idx_next[p+1] = pos_idx_reg[p];
                    pos_tot_next[p+1] = pos_tot_reg[p];
                end
            end
        end
    end

    // Sequencer next state and output register
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        key_next       = key_reg;
        round_next     = round_reg;
        emit_k_next    = emit_k_reg;
        out_valid_next = out_valid_reg;
        out_idx_next   = out_idx_reg;
        out_key_next   = out_key_reg;
        out_last_next  = out_last_reg;
        out_run_next   = out_run_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_LOAD:
            begin
                if (q_pop)
                begin
                    if (count_reg < gstr_pkg::CNT_W'(gstr_pkg::MAX_GROUPS))
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    if (q_rec.finish)
                    begin
                        state_next = ST_SORT;
                        key_next   = gstr_pkg::KEY_A;
                        round_next = '0;
                    end
                end
            end
            ST_SORT:
            begin
                round_next = round_reg + 1'b1;
                if (round_reg == gstr_pkg::IDX_W'(gstr_pkg::MAX_GROUPS - 1))
                begin
                    state_next  = ST_EMIT;
                    emit_k_next = '0;
                end
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = gstr_pkg::GIDX_W'(pos_idx_reg[emit_k_reg]);
                    out_key_next   = key_reg;
                    out_last_next  = emit_last;
                    out_run_next   = emit_last && (key_reg == gstr_pkg::KEY_C);
                    emit_k_next    = emit_k_reg + 1'b1;
                    if (emit_last)
                    begin
                        if (key_reg == gstr_pkg::KEY_C)
                        begin
                            state_next = ST_LOAD;
                            count_next = '0;
                        end
                        else
                        begin
                            state_next = ST_SORT;
                            key_next   = key_reg + 1'b1;
                            round_next = '0;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            key_reg       <= gstr_pkg::KEY_A;
            round_reg     <= '0;
            emit_k_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_idx_reg   <= '0;
            out_key_reg   <= gstr_pkg::KEY_A;
            out_last_reg  <= 1'b0;
            out_run_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            key_reg       <= key_next;
            round_reg     <= round_next;
            emit_k_reg    <= emit_k_next;
            out_valid_reg <= out_valid_next;
            out_idx_reg   <= out_idx_next;
            out_key_reg   <= out_key_next;
            out_last_reg  <= out_last_next;
            out_run_reg   <= out_run_next;
        end
    end

    // Hold rank row payload
    always_ff @(posedge clk)
    begin
        for (int p = 0; p < gstr_pkg::MAX_GROUPS; p++)
        begin
            pos_idx_reg[p] <= pos_idx_next[p];
            pos_tot_reg[p] <= pos_tot_next[p];
        end
    end

endmodule

// ----- tb/group_sum_triple_rank_sorter_tb.sv -----
// Self-checking testbench for the group-sum triple rank sorter.
`timescale 1ns / 1ps

module group_sum_triple_rank_sorter_tb;

    localparam int  CLK_HALF_NS  = 4;
    localparam int  HOLD_CYCLES  = 300;
    localparam int  TAIL_CYCLES  = 200;
    localparam longint RUN_LIMIT_NS = 2_000_000;

    // One ranked group as it should leave the block
    typedef struct {
        logic [gstr_pkg::GIDX_W-1:0] idx;
        gstr_pkg::rank_key_t         key;
        logic                        eol;
        logic                        eor;
    } rank_out_t;

    logic                          clk      = 1'b0;
    logic                          rst_n    = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [gstr_pkg::S_DATA_W-1:0] s_tdata  = '0;
    logic                          s_tlast  = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [gstr_pkg::M_DATA_W-1:0] m_tdata;
    logic [gstr_pkg::M_USER_W-1:0] m_tuser;
    logic                          m_tlast;

    // Predictor state: current set of groups and its ranking
    int                           members_in_group;
    int                           groups_stored;
    logic [gstr_pkg::TOTAL_W-1:0] running_total [3];
    logic [gstr_pkg::TOTAL_W-1:0] group_total [gstr_pkg::MAX_GROUPS][3];
    logic [gstr_pkg::GIDX_W-1:0]  rank_order [gstr_pkg::MAX_GROUPS];
    rank_out_t                    expected_ranks [$];

    int   err_count = 0;
    logic idle_on   = 1'b1;
    int   hold_req  = 0;
    int   hold_ack  = 0;
    int   hold_left = 0;
    int   stall_left = 0;

    group_sum_triple_rank_sorter u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #CLK_HALF_NS clk = ~clk;

    // Start a fresh set: counters and sums to zero, order back to identity
    function automatic void clear_set();
        members_in_group = 0;
        groups_stored    = 0;
        for (int f = 0; f < 3; f++)
            running_total[f] = '0;
        for (int i = 0; i < gstr_pkg::MAX_GROUPS; i++)
            rank_order[i] = gstr_pkg::GIDX_W'(i);
    endfunction

    // Stable descending bubble sort of the current order by one total
    function automatic void rank_by(input gstr_pkg::rank_key_t key, input int n);
        logic [gstr_pkg::GIDX_W-1:0] x;
        logic [gstr_pkg::GIDX_W-1:0] y;
        for (int p = 0; p + 1 < n; p++)
            for (int j = 0; j + 1 < n; j++)
            begin
                x = rank_order[j];
                y = rank_order[j + 1];
                // only a strictly smaller total moves down, so ties hold
                if (group_total[x][key] < group_total[y][key])
                begin
                    rank_order[j]     = y;
                    rank_order[j + 1] = x;
                end
            end
    endfunction

    // Fold one accepted member into the sums; on a closing member, rank the set
    function automatic void accumulate_member(input logic [gstr_pkg::SCORE_W-1:0] a,
                                              input logic [gstr_pkg::SCORE_W-1:0] b,
                                              input logic [gstr_pkg::SCORE_W-1:0] c,
                                              input logic eos);
        rank_out_t           r;
        gstr_pkg::rank_key_t key;
        int                  n;
        running_total[0] = running_total[0] + a;
        running_total[1] = running_total[1] + b;
        running_total[2] = running_total[2] + c;
        members_in_group++;
        if (members_in_group < gstr_pkg::MEMBERS_PER_GROUP)
            return;
        // store the group unless the set is already full
        if (groups_stored < gstr_pkg::MAX_GROUPS)
        begin
            for (int f = 0; f < 3; f++)
                group_total[groups_stored][f] = running_total[f];
            groups_stored++;
        end
        members_in_group = 0;
        for (int f = 0; f < 3; f++)
            running_total[f] = '0;
        if (!eos)
            return;
        n = groups_stored;
        for (int k = 0; k < 3; k++)
        begin
            key = gstr_pkg::rank_key_t'(k);
            rank_by(key, n);
            for (int i = 0; i < n; i++)
            begin
                r.idx = rank_order[i];
                r.key = key;
                r.eol = (i == n - 1);
                r.eor = (i == n - 1) && (key == gstr_pkg::KEY_C);
                expected_ranks.push_back(r);
            end
        end
        clear_set();
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        err_count++;
    endtask

    // Offer one member request, with an optional gap, and wait for the handshake
    task automatic send_member(input logic [gstr_pkg::SCORE_W-1:0] a,
                               input logic [gstr_pkg::SCORE_W-1:0] b,
                               input logic [gstr_pkg::SCORE_W-1:0] c,
                               input logic eos);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c, b, a};
        s_tlast  <= eos;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        accumulate_member(a, b, c, eos);
    endtask

    // Send one group; fields may be pinned to a common value so totals tie
    task automatic send_group(input logic closes_set);
        logic                         pinned [3];
        logic [gstr_pkg::SCORE_W-1:0] pin_val [3];
        logic [gstr_pkg::SCORE_W-1:0] v [3];
        for (int f = 0; f < 3; f++)
        begin
            pinned[f] = ($urandom_range(0, 1) == 1);
            case ($urandom_range(0, 2))
                0:       pin_val[f] = '0;
                1:       pin_val[f] = gstr_pkg::SCORE_W'(1);
                default: pin_val[f] = '1;
            endcase
        end
        for (int m = 0; m < gstr_pkg::MEMBERS_PER_GROUP; m++)
        begin
            for (int f = 0; f < 3; f++)
                v[f] = pinned[f] ? pin_val[f]
                                 : gstr_pkg::SCORE_W'($urandom_range(0, 16'hFFFF));
            // the end flag on an inner member is noise and must be ignored
            send_member(v[0], v[1], v[2],
                        (m == gstr_pkg::MEMBERS_PER_GROUP - 1)
                            ? closes_set : ($urandom_range(0, 3) == 0));
        end
    endtask

    task automatic send_set(input int n_groups);
        for (int g = 0; g < n_groups; g++)
            send_group(g == n_groups - 1);
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_ranks.size() != 0)
            @(posedge clk);
    endtask

    // Two groups at the score extremes: A decides, B ties and must keep
    // the A order, C reverses it
    task automatic test_extremes_and_ties();
        for (int m = 0; m < gstr_pkg::MEMBERS_PER_GROUP; m++)
            send_member(16'h0000, (m % 2) ? 16'h0000 : 16'hFFFF, 16'hFFFF,
                        m != gstr_pkg::MEMBERS_PER_GROUP - 1);
        for (int m = 0; m < gstr_pkg::MEMBERS_PER_GROUP; m++)
            send_member((m % 2) ? 16'h0000 : 16'hFFFF, (m % 2) ? 16'h0000 : 16'hFFFF,
                        16'h0000, m == gstr_pkg::MEMBERS_PER_GROUP - 1);
        drain_results();
    endtask

    // Hold the receiver off with a single-group set still to emit; the
    // next set then fills the queue and stalls the input
    task automatic test_input_backpressure();
        hold_req++;
        send_set(1);
    endtask

    // One group more than the capacity: the extra group must be dropped
    task automatic test_capacity_overflow();
        send_set(gstr_pkg::MAX_GROUPS + 1);
        drain_results();
    endtask

    // Full rate on both sides
    task automatic test_no_idle();
        idle_on = 1'b0;
        send_set(1);
        drain_results();
    endtask

    // Receiver: long hold on request, else random stall bursts
    always @(posedge clk)
    begin
        if (hold_ack != hold_req)
        begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 6);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Check each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        rank_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_ranks.size() == 0)
                report_mismatch($sformatf("unexpected result, group index %0d",
                                          m_tdata[gstr_pkg::GIDX_W-1:0]));
            else
            begin
                want = expected_ranks.pop_front();
                if (m_tdata[gstr_pkg::GIDX_W-1:0] !== want.idx)
                    report_mismatch($sformatf("group index %0d, want %0d",
                                              m_tdata[gstr_pkg::GIDX_W-1:0], want.idx));
                if (m_tuser[gstr_pkg::KEY_W-1:0] !== want.key)
                    report_mismatch($sformatf("ranking key %0d, want %0d",
                                              m_tuser[gstr_pkg::KEY_W-1:0], want.key));
                if (m_tlast !== want.eol)
                    report_mismatch($sformatf("end of list %b, want %b",
                                              m_tlast, want.eol));
                if (m_tuser[gstr_pkg::KEY_W] !== want.eor)
                    report_mismatch($sformatf("end of run %b, want %b",
                                              m_tuser[gstr_pkg::KEY_W], want.eor));
            end
        end
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        clear_set();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes_and_ties();
        test_input_backpressure();
        test_capacity_overflow();
        test_no_idle();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_ranks.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_ranks.size()));
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/gstr_pkg.sv
rtl/core/gstr_front.sv
rtl/core/gstr_queue.sv
rtl/core/gstr_back.sv
rtl/core/group_sum_triple_rank_sorter.sv
tb/group_sum_triple_rank_sorter_tb.sv
